### hw/rtl/mspfp_pkg.sv
// ----------------------------------------------------------------------------
// MSP request frame parser package
// Shared constants, phase encoding and the result record of the frame parser.
// ----------------------------------------------------------------------------
package mspfp_pkg;

   // Largest payload that is delivered; larger frames are parsed and dropped.
   localparam int unsigned MAX_PAYLOAD = 8;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned SIZE_W    = 4;
   localparam int unsigned PAYLOAD_W = 64;

   localparam logic [BYTE_W-1:0] SYM_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] SYM_M      = 8'h4D;
   localparam logic [BYTE_W-1:0] SYM_LT     = 8'h3C;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_M     = 3'd1,
      PH_DIR   = 3'd2,
      PH_SIZE  = 3'd3,
      PH_TYPE  = 3'd4,
      PH_DATA  = 3'd5,
      PH_CHECK = 3'd6
   } phase_type;

   typedef struct packed {
      logic                 hit;
      logic [SIZE_W-1:0]    frame_size;
      logic [BYTE_W-1:0]    frame_type;
      logic [PAYLOAD_W-1:0] frame_payload;
   } result_type;

endpackage

### hw/rtl/msp_request_frame_parser.sv
// ----------------------------------------------------------------------------
// MSP request frame parser
// Recognises '$' 'M' '<' size type payload checksum frames and emits them.
// ----------------------------------------------------------------------------
// One received byte is taken per beat, and a new byte can be taken in every
// cycle. The phase machine updates its state in the cycle the byte is taken;
// when a checksum byte matches and the frame holds at most eight payload
// bytes, the frame appears on the rsp_ channel in the following cycle from an
// output register. While that register holds an unread frame the block still
// takes bytes as long as rsp_ready is high in the same cycle.
module msp_request_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mspfp_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mspfp_pkg::SIZE_W-1:0]        rsp_frame_size,
   output logic [mspfp_pkg::BYTE_W-1:0]        rsp_frame_type,
   output logic [mspfp_pkg::PAYLOAD_W-1:0]     rsp_frame_payload
);

   mspfp_pkg::result_type                result;
   logic                                 req_take;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mspfp_pkg::SIZE_W-1:0]         size_ff;
   logic [mspfp_pkg::BYTE_W-1:0]         type_ff;
   logic [mspfp_pkg::PAYLOAD_W-1:0]      payload_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   mspfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_take (req_take),
      .rx_byte   (req_rx_byte),
      .result    (result)
   );

   assign rsp_valid_in = (req_take && result.hit) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && result.hit) begin
         size_ff    <= result.frame_size;
         type_ff    <= result.frame_type;
         payload_ff <= result.frame_payload;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_size    = size_ff;
   assign rsp_frame_type    = type_ff;
   assign rsp_frame_payload = payload_ff;

   // A delivered frame never exceeds the buffer.
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_size <= mspfp_pkg::SIZE_W'(mspfp_pkg::MAX_PAYLOAD)))
      else $error("frame size above buffer");

   // Payload bytes at or beyond the frame size are zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_frame_payload >> {rsp_frame_size, 3'b000}) == '0))
      else $error("unused payload bytes not zero");

   // A new frame only appears after a byte was taken.
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("frame without a received byte");

endmodule

### hw/rtl/mspfp_parser.sv
// ----------------------------------------------------------------------------
// MSP frame parser core
// Phase machine, running checksum and payload capture, one byte per beat.
// ----------------------------------------------------------------------------
module mspfp_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                byte_take,
   input  logic [mspfp_pkg::BYTE_W-1:0]        rx_byte,
   output mspfp_pkg::result_type               result
);

   mspfp_pkg::phase_type                 phase_ff, phase_in;
   logic [mspfp_pkg::BYTE_W-1:0]         xor_ff, xor_in;
   logic [mspfp_pkg::BYTE_W-1:0]         count_ff, count_in;
   logic [mspfp_pkg::BYTE_W-1:0]         size_ff, size_in;
   logic [mspfp_pkg::BYTE_W-1:0]         type_ff, type_in;
   logic [mspfp_pkg::PAYLOAD_W-1:0]      payload_ff, payload_in;
   logic [mspfp_pkg::BYTE_W-1:0]         count_next;
   logic                                 size_fits;

   assign count_next = count_ff + 8'd1;
   assign size_fits  = (size_ff <= mspfp_pkg::BYTE_W'(mspfp_pkg::MAX_PAYLOAD));

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         mspfp_pkg::PH_IDLE: begin
            if (rx_byte == mspfp_pkg::SYM_DOLLAR) phase_in = mspfp_pkg::PH_M;
         end
         mspfp_pkg::PH_M: begin
            phase_in = (rx_byte == mspfp_pkg::SYM_M) ? mspfp_pkg::PH_DIR
                                                     : mspfp_pkg::PH_IDLE;
         end
         mspfp_pkg::PH_DIR: begin
            phase_in = (rx_byte == mspfp_pkg::SYM_LT) ? mspfp_pkg::PH_SIZE
                                                      : mspfp_pkg::PH_IDLE;
         end
         mspfp_pkg::PH_SIZE: phase_in = mspfp_pkg::PH_TYPE;
         mspfp_pkg::PH_TYPE: begin
            phase_in = (size_ff != '0) ? mspfp_pkg::PH_DATA : mspfp_pkg::PH_CHECK;
         end
         mspfp_pkg::PH_DATA: begin
            if (count_next == size_ff) phase_in = mspfp_pkg::PH_CHECK;
         end
         mspfp_pkg::PH_CHECK: phase_in = mspfp_pkg::PH_IDLE;
         default:             phase_in = mspfp_pkg::PH_IDLE;
      endcase
   end

   // Datapath updates and the result of a checksum beat.
   always_comb begin
      xor_in     = xor_ff;
      count_in   = count_ff;
      size_in    = size_ff;
      type_in    = type_ff;
      payload_in = payload_ff;
      result.hit           = 1'b0;
      result.frame_size    = size_ff[mspfp_pkg::SIZE_W-1:0];
      result.frame_type    = type_ff;
      result.frame_payload = payload_ff;
      case (phase_ff)
         mspfp_pkg::PH_IDLE: begin
            xor_in   = '0;
            count_in = '0;
         end
         mspfp_pkg::PH_SIZE: begin
            size_in    = rx_byte;
            payload_in = '0;
            xor_in     = xor_ff ^ rx_byte;
         end
         mspfp_pkg::PH_TYPE: begin
            type_in = rx_byte;
            xor_in  = xor_ff ^ rx_byte;
         end
         mspfp_pkg::PH_DATA: begin
            // Bytes beyond the buffer still count towards the checksum.
            for (int i = 0; i < mspfp_pkg::MAX_PAYLOAD; i++) begin
               if (count_ff == mspfp_pkg::BYTE_W'(i))
                  payload_in[i*mspfp_pkg::BYTE_W +: mspfp_pkg::BYTE_W] = rx_byte;
            end
            xor_in   = xor_ff ^ rx_byte;
            count_in = count_next;
         end
         mspfp_pkg::PH_CHECK: begin
            result.hit = (xor_ff == rx_byte) && size_fits;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mspfp_pkg::PH_IDLE;
         xor_ff     <= '0;
         count_ff   <= '0;
         size_ff    <= '0;
         type_ff    <= '0;
         payload_ff <= '0;
      end else if (byte_take) begin
         phase_ff   <= phase_in;
         xor_ff     <= xor_in;
         count_ff   <= count_in;
         size_ff    <= size_in;
         type_ff    <= type_in;
         payload_ff <= payload_in;
      end
   end

endmodule

### tb/sv/msp_request_frame_parser_test.sv
// ----------------------------------------------------------------------------
// MSP request frame parser testbench
// Streams received bytes into the parser with random gaps and back-pressure.
// Each accepted byte runs through a software copy of the frame parser. Every
// frame the copy delivers is queued and compared field by field with the rsp_
// beats. The stimulus starts with directed frames and broken preambles,
// followed by mostly well-formed random frames mixed with noise.
// ----------------------------------------------------------------------------
module msp_request_frame_parser_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [mspfp_pkg::BYTE_W-1:0] rx;
      bit                           drain_first;
   } rx_beat_type;

   typedef struct {
      logic [mspfp_pkg::SIZE_W-1:0]    size;
      logic [mspfp_pkg::BYTE_W-1:0]    ftype;
      logic [mspfp_pkg::PAYLOAD_W-1:0] payload;
   } frame_rec_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [mspfp_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mspfp_pkg::SIZE_W-1:0]    rsp_frame_size;
   logic [mspfp_pkg::BYTE_W-1:0]    rsp_frame_type;
   logic [mspfp_pkg::PAYLOAD_W-1:0] rsp_frame_payload;

   rx_beat_type   rx_pending[$];
   frame_rec_type expected_frames[$];
   int            errors = 0;
   int            cycle_count = 0;
   bit            quiet_spell = 1'b0;
   bit            hold_next = 1'b0;
   int            good_frames = 0;

   // Parser copy used for prediction.
   mspfp_pkg::phase_type            ph_now = mspfp_pkg::PH_IDLE;
   logic [mspfp_pkg::BYTE_W-1:0]    xor_acc = '0;
   logic [mspfp_pkg::BYTE_W-1:0]    n_taken = '0;
   logic [mspfp_pkg::BYTE_W-1:0]    size_hold = '0;
   logic [mspfp_pkg::BYTE_W-1:0]    type_hold = '0;
   logic [mspfp_pkg::PAYLOAD_W-1:0] payload_hold = '0;

   msp_request_frame_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_size    (rsp_frame_size),
      .rsp_frame_type    (rsp_frame_type),
      .rsp_frame_payload (rsp_frame_payload)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic parse_rx_byte(input logic [mspfp_pkg::BYTE_W-1:0] b);
      frame_rec_type fr;
      case (ph_now)
         mspfp_pkg::PH_IDLE: begin
            xor_acc = '0;
            n_taken = '0;
            if (b == mspfp_pkg::SYM_DOLLAR) ph_now = mspfp_pkg::PH_M;
         end
         mspfp_pkg::PH_M: begin
            ph_now = (b == mspfp_pkg::SYM_M) ? mspfp_pkg::PH_DIR : mspfp_pkg::PH_IDLE;
         end
         mspfp_pkg::PH_DIR: begin
            ph_now = (b == mspfp_pkg::SYM_LT) ? mspfp_pkg::PH_SIZE : mspfp_pkg::PH_IDLE;
         end
         mspfp_pkg::PH_SIZE: begin
            size_hold = b;
            payload_hold = '0;
            xor_acc = xor_acc ^ b;
            ph_now = mspfp_pkg::PH_TYPE;
         end
         mspfp_pkg::PH_TYPE: begin
            type_hold = b;
            xor_acc = xor_acc ^ b;
            ph_now = (size_hold > 0) ? mspfp_pkg::PH_DATA : mspfp_pkg::PH_CHECK;
         end
         mspfp_pkg::PH_DATA: begin
            // Bytes past the buffer are still counted and summed, never stored.
            if (n_taken < mspfp_pkg::MAX_PAYLOAD)
               payload_hold = payload_hold |
                              (mspfp_pkg::PAYLOAD_W'(b) << (8 * n_taken));
            xor_acc = xor_acc ^ b;
            n_taken = n_taken + 8'd1;
            if (n_taken == size_hold) ph_now = mspfp_pkg::PH_CHECK;
         end
         mspfp_pkg::PH_CHECK: begin
            if (xor_acc == b && size_hold <= mspfp_pkg::MAX_PAYLOAD) begin
               fr.size = size_hold[mspfp_pkg::SIZE_W-1:0];
               fr.ftype = type_hold;
               fr.payload = payload_hold;
               expected_frames.push_back(fr);
            end
            ph_now = mspfp_pkg::PH_IDLE;
         end
         default: ph_now = mspfp_pkg::PH_IDLE;
      endcase
   endtask

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   task automatic push_byte(input logic [mspfp_pkg::BYTE_W-1:0] b);
      rx_beat_type beat;
      beat.rx = b;
      beat.drain_first = hold_next;
      hold_next = 1'b0;
      rx_pending.push_back(beat);
   endtask

   // fill < 0 gives random payload bytes; bad_sum spoils the checksum byte.
   task automatic push_frame(input int sz, input logic [mspfp_pkg::BYTE_W-1:0] ft,
                             input int fill, input bit bad_sum);
      logic [mspfp_pkg::BYTE_W-1:0] sum;
      logic [mspfp_pkg::BYTE_W-1:0] pb;
      sum = mspfp_pkg::BYTE_W'(sz) ^ ft;
      push_byte(mspfp_pkg::SYM_DOLLAR);
      push_byte(mspfp_pkg::SYM_M);
      push_byte(mspfp_pkg::SYM_LT);
      push_byte(mspfp_pkg::BYTE_W'(sz));
      push_byte(ft);
      for (int i = 0; i < sz; i++) begin
         pb = (fill < 0) ? mspfp_pkg::BYTE_W'($urandom_range(0, 255))
                         : mspfp_pkg::BYTE_W'(fill);
         sum = sum ^ pb;
         push_byte(pb);
      end
      if (bad_sum) sum = sum ^ mspfp_pkg::BYTE_W'($urandom_range(1, 255));
      push_byte(sum);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 128 == 0) quiet_spell <= ($urandom_range(0, 3) == 0);
   end

   // Driver: presents bytes from rx_pending, holding each until accepted.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_rx_byte(req_rx_byte);
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_pending.size() > 0 &&
                         !(rx_pending[0].drain_first && expected_frames.size() > 0)) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_pending[0].rx;
               void'(rx_pending.pop_front());
               gap_left = pick_gap(quiet_spell);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure and comparison with the predicted frames.
   int stall_left = 0;
   always @(posedge clock) begin
      frame_rec_type fr;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("unexpected frame: size %0d type %h payload %h",
                      rsp_frame_size, rsp_frame_type, rsp_frame_payload);
               errors++;
            end else begin
               fr = expected_frames.pop_front();
               if (rsp_frame_size !== fr.size) begin
                  $error("frame_size: expected %0d, actual %0d", fr.size, rsp_frame_size);
                  errors++;
               end
               if (rsp_frame_type !== fr.ftype) begin
                  $error("frame_type: expected %h, actual %h", fr.ftype, rsp_frame_type);
                  errors++;
               end
               if (rsp_frame_payload !== fr.payload) begin
                  $error("frame_payload: expected %h, actual %h", fr.payload,
                         rsp_frame_payload);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap(quiet_spell);
         end
      end
   end

   initial begin
      int r;
      int sz;

      // Idle bytes at both extremes, then broken preambles.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(mspfp_pkg::SYM_DOLLAR);
      push_byte(8'h4E);
      push_byte(mspfp_pkg::SYM_DOLLAR);
      push_byte(mspfp_pkg::SYM_M);
      push_byte(8'h3D);
      // A second dollar in place of 'M' drops the frame and is not a new start.
      push_byte(mspfp_pkg::SYM_DOLLAR);
      push_byte(mspfp_pkg::SYM_DOLLAR);
      push_byte(mspfp_pkg::SYM_M);
      push_byte(mspfp_pkg::SYM_LT);
      push_byte(8'h00);
      push_byte(8'h00);
      push_byte(8'h00);
      push_frame(0, 8'hFF, -1, 1'b0);
      push_frame(mspfp_pkg::MAX_PAYLOAD, 8'h00, 8'hFF, 1'b0);
      push_frame(mspfp_pkg::MAX_PAYLOAD, 8'hA5, 8'h00, 1'b0);
      push_frame(mspfp_pkg::MAX_PAYLOAD + 1, 8'h11, -1, 1'b0);
      push_frame(1, 8'h7E, -1, 1'b1);
      push_frame(3, 8'h80, -1, 1'b0);

      hold_next = 1'b1;
      while (rx_pending.size() < 500 || good_frames < 40) begin
         r = $urandom_range(0, 99);
         if (rx_pending.size() > 250 && rx_pending.size() < 265) hold_next = 1'b1;
         if (r < 70) begin
            push_frame($urandom_range(0, mspfp_pkg::MAX_PAYLOAD),
                       mspfp_pkg::BYTE_W'($urandom_range(0, 255)), -1, 1'b0);
            good_frames++;
         end else if (r < 78) begin
            push_frame($urandom_range(0, mspfp_pkg::MAX_PAYLOAD),
                       mspfp_pkg::BYTE_W'($urandom_range(0, 255)), -1, 1'b1);
         end else if (r < 85) begin
            sz = ($urandom_range(0, 4) == 0) ?
                 $urandom_range(mspfp_pkg::MAX_PAYLOAD + 1, 255) :
                 $urandom_range(mspfp_pkg::MAX_PAYLOAD + 1, 12);
            push_frame(sz, mspfp_pkg::BYTE_W'($urandom_range(0, 255)), -1,
                       $urandom_range(0, 1));
         end else if (r < 93) begin
            repeat ($urandom_range(1, 4))
               push_byte(mspfp_pkg::BYTE_W'($urandom_range(0, 255)));
         end else begin
            push_byte(mspfp_pkg::SYM_DOLLAR);
            if ($urandom_range(0, 1)) push_byte(mspfp_pkg::SYM_M);
            push_byte(mspfp_pkg::BYTE_W'($urandom_range(0, 255)));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while ((rx_pending.size() > 0 || req_valid || expected_frames.size() > 0) &&
             cycle_count < CYCLE_LIMIT)
         @(posedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("msp_request_frame_parser_test: FAIL");
      end else begin
         repeat (8) @(posedge clock);
         if (expected_frames.size() > 0) begin
            $error("%0d expected frames never delivered", expected_frames.size());
            errors++;
         end
         if (errors == 0) begin
            $display("msp_request_frame_parser_test: PASS");
         end else begin
            $display("msp_request_frame_parser_test: FAIL");
         end
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/mspfp_pkg.sv
hw/rtl/mspfp_parser.sv
hw/rtl/msp_request_frame_parser.sv
tb/sv/msp_request_frame_parser_test.sv
